// ----- src/lsd_pkg.sv -----
package lsd_pkg;

  // Store depth used when the top level is not told otherwise.
  localparam int unsigned MAX_CELLS_DEF = 1024;

  // Grid dimensions as written to the registers, and their useful limit.
  localparam int unsigned DIM_W   = 6;
  localparam int unsigned DIM_MAX = 32;

  // A cell count or a deal position never exceeds 32 * 32.
  localparam int unsigned CELLS_W = 11;

  // Generator: x' = 48271 * x mod (2^31 - 1).
  localparam int unsigned           RNG_W      = 31;
  localparam int unsigned           MUL_W      = 16;
  localparam int unsigned           PROD_W     = RNG_W + MUL_W;
  localparam logic [MUL_W-1:0]      LEHMER_MUL = 16'd48271;
  localparam logic [RNG_W-1:0]      LEHMER_MOD = 31'h7FFF_FFFF;

  // Tag kept beside every table entry; a tag equal to the current epoch marks
  // an entry written since the last start.
  localparam int unsigned EPOCH_W = 8;

  // Stream field widths.
  localparam int unsigned SEED_W    = 11;
  localparam int unsigned IDX_OUT_W = 10;
  localparam int unsigned RC_W      = 5;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 24;

  // Configuration register indices.
  localparam int unsigned           CFG_ADDR_W       = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLUMNS = 1'b1;

  // Request operation codes.
  localparam logic OP_START = 1'b0;

  // Divider: two quotient bits per cycle.
  localparam int unsigned DIV_DVD_W = 32;
  localparam int unsigned DIV_DVS_W = CELLS_W;
  localparam int unsigned DIV_ITER  = DIV_DVD_W / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITER);

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quot;
    logic [DIV_DVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [RNG_W-1:0] x;
  } lmr_req_t;

  typedef struct packed {
    logic             done;
    logic [RNG_W-1:0] y;
  } lmr_rsp_t;

endpackage

// ----- src/lsd_mem.sv -----
module lsd_mem #(
  parameter int unsigned  DEPTH = lsd_pkg::MAX_CELLS_DEF,
  parameter int unsigned  WIDTH = lsd_pkg::EPOCH_W + $clog2(lsd_pkg::MAX_CELLS_DEF),
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lsd_lehmer.sv -----
module lsd_lehmer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsd_pkg::lmr_req_t req_i,
  output lsd_pkg::lmr_rsp_t rsp_o
);

  import lsd_pkg::*;

  logic              prod_vld_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;
  logic              done_q;
  logic [RNG_W-1:0]  y_q;
  logic [RNG_W-1:0]  y_d;
  logic [RNG_W:0]    fold;

  // Product register: the 31 by 16 bit product.
  assign prod_d = req_i.x * LEHMER_MUL;

  // Result register: 2^31 is one modulo the Mersenne prime, so the high part folds
  // onto the low part and one subtraction finishes the reduction.
  always_comb begin
    fold = (RNG_W+1)'(prod_q[RNG_W-1:0]) + (RNG_W+1)'(prod_q[PROD_W-1:RNG_W]);
    if (fold >= (RNG_W+1)'(LEHMER_MOD)) begin
      y_d = RNG_W'(fold - (RNG_W+1)'(LEHMER_MOD));
    end else begin
      y_d = RNG_W'(fold);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      prod_vld_q <= req_i.start;
      done_q     <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    y_q    <= y_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.y    = y_q;

endmodule

// ----- src/lsd_div.sv -----
module lsd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsd_pkg::div_req_t req_i,
  output lsd_pkg::div_rsp_t rsp_o
);

  import lsd_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [DIV_DVS_W-1:0] rem_q, rem_d;
  logic [DIV_DVS_W-1:0] dvs_q, dvs_d;

  logic [DIV_DVS_W:0]   t1, t2;
  logic                 ge1, ge2;
  logic [DIV_DVS_W-1:0] r1, r2;
  logic [DIV_DVD_W-1:0] d1, d2;

  // Two restoring steps a cycle; the quotient bits shift into the dividend
  // register from below as its bits leave at the top.
  always_comb begin
    t1  = {rem_q, dvd_q[DIV_DVD_W-1]};
    ge1 = t1 >= {1'b0, dvs_q};
    r1  = ge1 ? DIV_DVS_W'(t1 - {1'b0, dvs_q}) : DIV_DVS_W'(t1);
    d1  = {dvd_q[DIV_DVD_W-2:0], ge1};
    t2  = {r1, d1[DIV_DVD_W-1]};
    ge2 = t2 >= {1'b0, dvs_q};
    r2  = ge2 ? DIV_DVS_W'(t2 - {1'b0, dvs_q}) : DIV_DVS_W'(t2);
    d2  = {d1[DIV_DVD_W-2:0], ge2};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = d2;
      rem_d = r2;
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_ITER - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("partial remainder reached the divisor");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider finished without running");

  a_start_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (!busy_q && (req_i.divisor != '0)))
    else $error("divider started while busy or with a zero divisor");

endmodule

// ----- src/lehmer_shuffled_cell_dealer.sv -----
// Channel     | Direction | Contents
// s_axis      | in        | tdata: seed_count; tuser: op (start or next)
// m_axis      | out       | tdata: cell_index, cell_row, cell_column; tuser: exhausted
// cfg         | in        | write-only: grid_rows (index 0), grid_columns (index 1)
//
// A next request runs the generator, the draw division and the table swap, then a
// second pass through the same divider for row and column; the result is then loaded
// into the m_axis output register.
// Once after reset and on every 255th start, a clearing pass writes a zero tag to all
// MAX_CELLS entries, one a cycle, with s_axis_tready low.
// Register writes are taken at any time. A waiting result only holds up the next one.
module lehmer_shuffled_cell_dealer #(
  parameter int unsigned MAX_CELLS = lsd_pkg::MAX_CELLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input requests.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lsd_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [10:0] seed_count
  input  logic                               s_axis_tuser,  // [0] op
  // Dealt cells.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [9:0] cell_index, [14:10] cell_row, [19:15] cell_column
  output logic [lsd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                               m_axis_tuser,  // [0] exhausted
  // Register writes.
  input  logic                               cfg_we_i,
  input  logic [lsd_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [lsd_pkg::DIM_W-1:0]          cfg_data_i
);

  import lsd_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_CELLS);
  localparam int unsigned ENTRY_W = EPOCH_W + IDX_W;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_SEED   = 10'b00_0000_0100,
    ST_STEP   = 10'b00_0000_1000,
    ST_DRAW   = 10'b00_0001_0000,
    ST_RD_J   = 10'b00_0010_0000,
    ST_WR_POS = 10'b00_0100_0000,
    ST_WR_J   = 10'b00_1000_0000,
    ST_ROWCOL = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } state_e;

  // Register values outside 1..32 behave as the nearest end of that range.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [DIM_W-1:0]   rows_q, cols_q;
  logic [DIM_W-1:0]   rows_w, cols_w;
  logic [2*DIM_W-1:0] cells_prod;
  logic [CELLS_W-1:0] cells_w;

  logic [CELLS_W-1:0] pos_q, pos_d;
  logic [CELLS_W-1:0] j_q, j_d;
  logic [RNG_W-1:0]   rng_q, rng_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [IDX_W-1:0]   rd_addr_q, rd_addr_d;
  logic [IDX_W-1:0]   a_q, a_d;
  logic [IDX_W-1:0]   b_q, b_d;

  // Result waiting for the output register.
  logic [IDX_OUT_W-1:0] res_idx_q, res_idx_d;
  logic [RC_W-1:0]      res_row_q, res_row_d;
  logic [RC_W-1:0]      res_col_q, res_col_d;
  logic                 res_exh_q, res_exh_d;

  // Output register.
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic                 m_user_q, m_user_d;

  // Table memory.
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic [EPOCH_W-1:0] rd_tag;
  logic [IDX_W-1:0]   entry_w;

  lmr_req_t lmr_req;
  lmr_rsp_t lmr_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_fire;

  // Grid size, recomputed; users change the registers only while idle, unenforced.
  assign rows_w     = clamp_dim(rows_q);
  assign cols_w     = clamp_dim(cols_q);
  assign cells_prod = rows_w * cols_w;

  always_comb begin
    if (32'(cells_prod) > 32'(MAX_CELLS)) begin
      cells_w = CELLS_W'(MAX_CELLS);
    end else begin
      cells_w = CELLS_W'(cells_prod);
    end
  end

  // An entry whose tag is not the current epoch has not been written since the
  // last start and reads as its own index.
  assign rd_tag  = mem_rdata[ENTRY_W-1 -: EPOCH_W];
  assign entry_w = (rd_tag == epoch_q) ? mem_rdata[IDX_W-1:0] : rd_addr_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(1);
      cols_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_GRID_ROWS:    rows_q <= cfg_data_i;
        REG_GRID_COLUMNS: cols_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Sequencer. A deal runs generator, draw division, read of the entry at the
  // position, read of the drawn entry and the two write-backs; the row and column
  // division starts with the first write-back. Each memory access is its own step,
  // so no read ever meets a write to the same entry in flight.
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    j_d       = j_q;
    rng_d     = rng_q;
    epoch_d   = epoch_q;
    clr_d     = clr_q;
    rd_addr_d = rd_addr_q;
    a_d       = a_q;
    b_d       = b_q;
    res_idx_d = res_idx_q;
    res_row_d = res_row_q;
    res_col_d = res_col_q;
    res_exh_d = res_exh_q;

    mem_we    = 1'b0;
    mem_waddr = IDX_W'(pos_q);
    mem_wdata = {epoch_q, b_q};
    mem_re    = 1'b0;
    mem_raddr = IDX_W'(pos_q);

    lmr_req.start = 1'b0;
    lmr_req.x     = rng_q;

    div_req.start    = 1'b0;
    div_req.dividend = DIV_DVD_W'(lmr_rsp.y);
    div_req.divisor  = cells_w - pos_q;

    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_CELLS - 1)) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == OP_START) begin
            lmr_req.start = 1'b1;
            lmr_req.x     = RNG_W'(s_axis_tdata[SEED_W-1:0]);
            state_d       = ST_SEED;
          end else if (pos_q >= cells_w) begin
            // Every cell dealt: the generator and the position stay put.
            res_idx_d = '0;
            res_row_d = '0;
            res_col_d = '0;
            res_exh_d = 1'b1;
            state_d   = ST_EMIT;
          end else begin
            lmr_req.start = 1'b1;
            state_d       = ST_STEP;
          end
        end
      end

      ST_SEED: begin
        if (lmr_rsp.done) begin
          rng_d = lmr_rsp.y;
          pos_d = '0;
          // A fresh epoch invalidates the whole table at once; when the tag
          // would wrap, the table is swept back to tag zero instead.
          if (epoch_q == '1) begin
            epoch_d = EPOCH_FIRST;
            state_d = ST_CLEAR;
          end else begin
            epoch_d = epoch_q + EPOCH_W'(1);
            state_d = ST_IDLE;
          end
        end
      end

      ST_STEP: begin
        if (lmr_rsp.done) begin
          rng_d         = lmr_rsp.y;
          div_req.start = 1'b1;
          state_d       = ST_DRAW;
        end
      end

      ST_DRAW: begin
        if (div_rsp.done) begin
          j_d       = pos_q + div_rsp.rem;
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(pos_q);
          rd_addr_d = IDX_W'(pos_q);
          state_d   = ST_RD_J;
        end
      end

      ST_RD_J: begin
        a_d       = entry_w;
        mem_re    = 1'b1;
        mem_raddr = IDX_W'(j_q);
        rd_addr_d = IDX_W'(j_q);
        state_d   = ST_WR_POS;
      end

      ST_WR_POS: begin
        b_d              = entry_w;
        mem_we           = 1'b1;
        mem_waddr        = IDX_W'(pos_q);
        mem_wdata        = {epoch_q, entry_w};
        div_req.start    = 1'b1;
        div_req.dividend = DIV_DVD_W'(entry_w);
        div_req.divisor  = DIV_DVS_W'(cols_w);
        state_d          = ST_WR_J;
      end

      ST_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(j_q);
        mem_wdata = {epoch_q, a_q};
        pos_d     = pos_q + CELLS_W'(1);
        state_d   = ST_ROWCOL;
      end

      ST_ROWCOL: begin
        if (div_rsp.done) begin
          res_idx_d = IDX_OUT_W'(b_q);
          res_row_d = RC_W'(div_rsp.quot);
          res_col_d = RC_W'(div_rsp.rem);
          res_exh_d = 1'b0;
          state_d   = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = M_TDATA_W'({res_col_q, res_row_q, res_idx_q});
          m_user_d  = res_exh_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      pos_q     <= '0;
      rng_q     <= '0;
      epoch_q   <= EPOCH_FIRST;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      rng_q     <= rng_d;
      epoch_q   <= epoch_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q       <= j_d;
    rd_addr_q <= rd_addr_d;
    a_q       <= a_d;
    b_q       <= b_d;
    res_idx_q <= res_idx_d;
    res_row_q <= res_row_d;
    res_col_q <= res_col_d;
    res_exh_q <= res_exh_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  lsd_lehmer u_lehmer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lmr_req),
    .rsp_o  (lmr_rsp)
  );

  lsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lsd_mem #(
    .DEPTH (MAX_CELLS),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  a_draw_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_J) |-> ((j_q >= pos_q) && (j_q < cells_w)))
    else $error("drawn entry lies outside the undealt part of the table");

  a_write_tag_current : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q != ST_CLEAR)) |-> (mem_wdata[ENTRY_W-1 -: EPOCH_W] == epoch_q))
    else $error("table write carries a stale epoch tag");

  a_epoch_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("epoch equals the tag of cleared entries");

endmodule

// ----- dv/tb_lehmer_shuffled_cell_dealer.sv -----
`timescale 1ns / 100ps

module tb_lehmer_shuffled_cell_dealer;
  import lsd_pkg::*;

  // The package names only the start code; the deal code is its complement.
  localparam logic OP_NEXT = ~OP_START;

  // Longest legal stretch without any handshake: a clearing pass over the
  // whole table, a deal and both sides' longest stalls, taken several times
  // over.
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic              op;
    logic [SEED_W-1:0] seed;
  } deal_request_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] cell_index;
    logic [RC_W-1:0]      cell_row;
    logic [RC_W-1:0]      cell_column;
    logic                 exhausted;
  } dealt_cell_t;

  // Every input starts from a known value at time zero.
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [DIM_W-1:0]      cfg_data_i    = '0;

  lehmer_shuffled_cell_dealer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Requests waiting to be driven, and cells the shuffle predicts will come
  // back, oldest first.
  deal_request_t request_q[$];
  dealt_cell_t   dealt_cells_q[$];

  int unsigned mismatch_count = 0;
  int unsigned queued_total   = 0;
  int unsigned starts_queued  = 0;
  int unsigned send_gap       = 0;
  int unsigned accept_gap     = 0;
  int unsigned quiet_cycles   = 0;
  bit          calm_tail      = 1'b0;

  // Shadow of the block: the two grid registers as written, the cell table
  // with a flag per entry (a clear flag reads as its own index), the deal
  // position and the generator.
  logic [DIM_W-1:0]     model_rows = 6'd1;
  logic [DIM_W-1:0]     model_cols = 6'd1;
  logic [IDX_OUT_W-1:0] cell_perm  [MAX_CELLS_DEF];
  bit                   cell_taken [MAX_CELLS_DEF];
  int unsigned          deal_pos   = 0;
  logic [RNG_W-1:0]     gen_state  = '0;

  // Register values of zero behave as one and anything above 32 as 32.
  function automatic int unsigned dim_eff(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return 32'(v);
  endfunction

  function automatic int unsigned grid_cells();
    int unsigned cells;
    cells = dim_eff(model_rows) * dim_eff(model_cols);
    return (cells > MAX_CELLS_DEF) ? MAX_CELLS_DEF : cells;
  endfunction

  // One step of the minimal-standard generator, x * 48271 mod (2^31 - 1).
  function automatic logic [RNG_W-1:0] lehmer_step(input logic [RNG_W-1:0] x);
    logic [63:0] prod;
    prod = 64'(x) * 64'(LEHMER_MUL);
    return RNG_W'(prod % 64'(LEHMER_MOD));
  endfunction

  // Applies one accepted request to the shadow state. A start reseeds the
  // generator and resets the table to the identity; a deal either reports
  // exhaustion, leaving everything untouched, or swaps the drawn entry into
  // the current position and predicts it.
  task automatic shuffle_step(input logic op, input logic [SEED_W-1:0] seed);
    int unsigned          cells;
    int unsigned          pos;
    int unsigned          pick;
    int unsigned          cols_eff;
    logic [IDX_OUT_W-1:0] here;
    logic [IDX_OUT_W-1:0] drawn;
    dealt_cell_t          dealt;
    cells    = grid_cells();
    cols_eff = dim_eff(model_cols);
    dealt    = '0;
    if (op == OP_START) begin
      gen_state = lehmer_step(RNG_W'(seed));
      foreach (cell_taken[k]) cell_taken[k] = 1'b0;
      deal_pos = 0;
    end else if (deal_pos >= cells) begin
      dealt.exhausted = 1'b1;
      dealt_cells_q.push_back(dealt);
    end else begin
      gen_state = lehmer_step(gen_state);
      pos   = deal_pos;
      pick  = pos + gen_state % (cells - pos);
      here  = cell_taken[pos]  ? cell_perm[pos]  : IDX_OUT_W'(pos);
      drawn = cell_taken[pick] ? cell_perm[pick] : IDX_OUT_W'(pick);
      cell_perm[pos]   = drawn;
      cell_taken[pos]  = 1'b1;
      cell_perm[pick]  = here;
      cell_taken[pick] = 1'b1;
      deal_pos = pos + 1;
      // Row and column use the column count in force now, cut to five bits.
      dealt.cell_index  = drawn;
      dealt.cell_row    = RC_W'(drawn / cols_eff);
      dealt.cell_column = RC_W'(drawn % cols_eff);
      dealt_cells_q.push_back(dealt);
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Sender. Each accepted request is fed to the shadow at the edge that takes
  // it. A new request is only put up once the previous one has gone, and a
  // random pause may follow any request.
  always @(posedge clk_i) begin : request_driver
    deal_request_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        shuffle_step(s_axis_tuser, s_axis_tdata[SEED_W-1:0]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_TDATA_W'(req.seed);
          s_axis_tuser  <= req.op;
          if (!calm_tail && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 16);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every cell that leaves the block is checked field by field
  // against the oldest prediction; tready drops in random bursts.
  always @(posedge clk_i) begin : cell_monitor
    dealt_cell_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (dealt_cells_q.size() == 0) begin
          $error("Unexpected dealt cell: tdata %h, tuser %b", m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          want = dealt_cells_q.pop_front();
          check_field("cell_index", 32'(want.cell_index), 32'(m_axis_tdata[9:0]));
          check_field("cell_row", 32'(want.cell_row), 32'(m_axis_tdata[14:10]));
          check_field("cell_column", 32'(want.cell_column), 32'(m_axis_tdata[19:15]));
          check_field("exhausted", 32'(want.exhausted), 32'(m_axis_tuser));
        end
      end
      if (accept_gap != 0) begin
        accept_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
          accept_gap = $urandom_range(1, 16);
        end
      end
    end
  end

  // Ends the run if neither side completes a handshake for too long.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic queue_request(input logic op, input logic [SEED_W-1:0] seed);
    deal_request_t req;
    req.op   = op;
    req.seed = seed;
    request_q.push_back(req);
    queued_total++;
    if (op == OP_START) starts_queued++;
  endtask

  // Seeds lean on the meaningful range, with zero and the unused top codes
  // turning up now and then.
  function automatic logic [SEED_W-1:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SEED_W'($urandom_range(1025, 2047));
      default: return SEED_W'($urandom_range(0, 1024));
    endcase
  endfunction

  // Waits until every request has gone, every predicted cell has come back
  // and the block is ready again. Sampled on the falling edge, when all of
  // the rising edge's updates have settled.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid || !s_axis_tready ||
           dealt_cells_q.size() != 0);
  endtask

  // Both registers are only written while the block is idle.
  task automatic set_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    wait_quiet();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= REG_GRID_ROWS;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_addr_i <= REG_GRID_COLUMNS;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    model_rows = rows;
    model_cols = cols;
  endtask

  initial begin : stimulus
    int unsigned cells;
    int unsigned deal_count;
    int unsigned seq_count;
    bit          carry_on;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A single-cell grid straight out of reset: deal before any start, then
    // exhaustion, then the same again after a zero seed.
    queue_request(OP_NEXT, '0);
    queue_request(OP_NEXT, '1);
    queue_request(OP_START, '0);
    queue_request(OP_NEXT, '0);
    queue_request(OP_NEXT, '0);

    // Out-of-range registers: zero rows acts as one, 63 columns as 32.
    set_grid('0, '1);
    queue_request(OP_START, SEED_W'(1024));
    repeat (3) queue_request(OP_NEXT, '0);
    queue_request(OP_START, '1);
    repeat (2) queue_request(OP_NEXT, '1);
    // A zero seed keeps the generator at zero, so cells come in order.
    queue_request(OP_START, '0);
    repeat (3) queue_request(OP_NEXT, '0);

    // Shrinking the grid part way through a shuffle.
    set_grid(6'd3, 6'd2);
    queue_request(OP_START, SEED_W'(1));
    repeat (2) queue_request(OP_NEXT, '0);
    set_grid(6'd1, 6'd3);
    repeat (2) queue_request(OP_NEXT, '0);

    // The largest grid dealt to the end and two past it.
    set_grid(6'd32, 6'd40);
    queue_request(OP_START, pick_seed());
    repeat (MAX_CELLS_DEF + 2) queue_request(OP_NEXT, SEED_W'($urandom_range(0, 2047)));

    // Random phases: mostly small grids, so that shuffles run to exhaustion,
    // with the odd large one dealt only part way. Some phases carry on with
    // the shuffle left by the previous grid.
    while (queued_total < 1450) begin
      if ($urandom_range(0, 7) != 0) begin
        set_grid(DIM_W'($urandom_range(0, 6)), DIM_W'($urandom_range(0, 8)));
      end else begin
        set_grid(DIM_W'($urandom_range(0, 63)), DIM_W'($urandom_range(0, 63)));
      end
      cells     = grid_cells();
      carry_on  = ($urandom_range(0, 3) == 0);
      seq_count = $urandom_range(1, 4);
      for (int s = 0; s < seq_count; s++) begin
        if (!(carry_on && s == 0)) queue_request(OP_START, pick_seed());
        deal_count = $urandom_range(0, ((cells > 40) ? 40 : cells) + 2);
        repeat (deal_count) queue_request(OP_NEXT, SEED_W'($urandom_range(0, 2047)));
        if ($urandom_range(0, 9) == 0) begin
          queue_request(logic'($urandom_range(0, 1)), SEED_W'($urandom_range(0, 2047)));
        end
      end
    end

    // Enough starts to wrap the table's tag at least once, each mostly
    // followed by a deal from the freshly cleared table.
    set_grid(DIM_W'($urandom_range(1, 5)), DIM_W'($urandom_range(1, 5)));
    while (starts_queued < 300) begin
      queue_request(OP_START, pick_seed());
      if ($urandom_range(0, 2) != 0) queue_request(OP_NEXT, '0);
    end

    // Closing phase at full speed on both sides.
    set_grid(6'd4, 6'd4);
    calm_tail = 1'b1;
    queue_request(OP_START, pick_seed());
    repeat (18) queue_request(OP_NEXT, '0);

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
